// File: design/ftgc_pkg.sv
// ----------------------------------------------------------------------------
// ftgc_pkg: shared types and constants for the gravity compensation block
// Holds the fixed-point constants, the CORDIC arctangent table, the
// saturation helper and the micro-step table of the shared multiplier.
// ----------------------------------------------------------------------------
package ftgc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_GRAVITY_WEIGHT  = 3'd0;
  localparam logic [2:0] REG_FORCE_OFFSET_XY = 3'd1;
  localparam logic [2:0] REG_OFFSET_FZ_TX    = 3'd2;
  localparam logic [2:0] REG_OFFSET_TY_TZ    = 3'd3;
  localparam logic [2:0] REG_MOUNT_TILT_XY   = 3'd4;
  localparam logic [2:0] REG_ARM_PXY         = 3'd5;
  localparam logic [2:0] REG_ARM_PZ          = 3'd6;

  // Angle constants in Q.28, CORDIC start value in Q.30.
  localparam logic signed [35:0] Q28_TWO_PI  = 36'sd1686629713;
  localparam logic signed [35:0] Q28_PI      = 36'sd843314857;
  localparam logic signed [35:0] Q28_HALF_PI = 36'sd421657428;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Raw scaling: x*65536/1e6 is done as a divide by 15625 of x*1024 + 7812,
  // using reciprocal multiplies that are exact over the operand ranges.
  localparam logic signed [32:0] RECIP_15625_K45 = 33'sd2251799814;
  localparam logic signed [32:0] RECIP_15625_K38 = 33'sd17592187;
  localparam logic signed [32:0] DIV_15625       = 33'sd15625;
  localparam logic [23:0]        ROUND_BIAS      = 24'd7812;

  // Operand selects, writeback kinds and one micro step of the sequencer.
  typedef enum logic [2:0] {
    OPA_G, OPA_T1, OPA_T2, OPA_U, OPA_QA, OPA_V, OPA_SS, OPA_CS
  } opa_t;

  typedef enum logic [3:0] {
    OPB_X, OPB_Y, OPB_PX, OPB_PY, OPB_PZ, OPB_D0, OPB_D1, OPB_D2,
    OPB_M1, OPB_K15625, OPB_M2, OPB_S5, OPB_C5, OPB_S6, OPB_C6
  } opb_t;

  typedef enum logic [2:0] {
    WB_T1, WB_T2, WB_ADD, WB_SUB, WB_QA, WB_V, WB_QADD
  } wb_t;

  typedef struct packed {
    opa_t       opa;
    opb_t       opb;
    wb_t        wb;
    logic [2:0] dst;
    logic       last;
  } uop_t;

  localparam logic [5:0] WRENCH_FIRST = 6'd0;
  localparam logic [5:0] JOINT_FIRST  = 6'd43;
  localparam logic [5:0] STEP_LAST    = 6'd49;

  // Arctangent of 2^-i in Q.28.
  function automatic logic [27:0] atan_q28(input logic [4:0] i);
    logic [27:0] r;
    case (i)
      5'd0:  r = 28'd210828714;
      5'd1:  r = 28'd124459457;
      5'd2:  r = 28'd65760959;
      5'd3:  r = 28'd33381290;
      5'd4:  r = 28'd16755422;
      5'd5:  r = 28'd8385879;
      5'd6:  r = 28'd4193963;
      5'd7:  r = 28'd2097109;
      5'd8:  r = 28'd1048571;
      5'd9:  r = 28'd524287;
      5'd10: r = 28'd262144;
      5'd11: r = 28'd131072;
      5'd12: r = 28'd65536;
      5'd13: r = 28'd32768;
      5'd14: r = 28'd16384;
      5'd15: r = 28'd8192;
      5'd16: r = 28'd4096;
      5'd17: r = 28'd2048;
      5'd18: r = 28'd1024;
      5'd19: r = 28'd512;
      5'd20: r = 28'd256;
      5'd21: r = 28'd128;
      5'd22: r = 28'd64;
      5'd23: r = 28'd32;
      default: r = 28'd0;
    endcase
    return r;
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  function automatic uop_t mk(input opa_t a, input opb_t b, input wb_t w,
                              input logic [2:0] d, input logic l);
    uop_t u;
    u.opa  = a;
    u.opb  = b;
    u.wb   = w;
    u.dst  = d;
    u.last = l;
    return u;
  endfunction

  // Micro-step table. Steps 0..17 scale the six raw channels, 18..42 build
  // the wrench terms, 43..49 build the three gravity-direction terms.
  function automatic uop_t ucode(input logic [5:0] step);
    uop_t u;
    case (step)
      6'd0:  u = mk(OPA_U,  OPB_M1,     WB_QA,   3'd0, 1'b0);
      6'd1:  u = mk(OPA_QA, OPB_K15625, WB_V,    3'd0, 1'b0);
      6'd2:  u = mk(OPA_V,  OPB_M2,     WB_QADD, 3'd0, 1'b0);
      6'd3:  u = mk(OPA_U,  OPB_M1,     WB_QA,   3'd1, 1'b0);
      6'd4:  u = mk(OPA_QA, OPB_K15625, WB_V,    3'd1, 1'b0);
      6'd5:  u = mk(OPA_V,  OPB_M2,     WB_QADD, 3'd1, 1'b0);
      6'd6:  u = mk(OPA_U,  OPB_M1,     WB_QA,   3'd2, 1'b0);
      6'd7:  u = mk(OPA_QA, OPB_K15625, WB_V,    3'd2, 1'b0);
      6'd8:  u = mk(OPA_V,  OPB_M2,     WB_QADD, 3'd2, 1'b0);
      6'd9:  u = mk(OPA_U,  OPB_M1,     WB_QA,   3'd3, 1'b0);
      6'd10: u = mk(OPA_QA, OPB_K15625, WB_V,    3'd3, 1'b0);
      6'd11: u = mk(OPA_V,  OPB_M2,     WB_QADD, 3'd3, 1'b0);
      6'd12: u = mk(OPA_U,  OPB_M1,     WB_QA,   3'd4, 1'b0);
      6'd13: u = mk(OPA_QA, OPB_K15625, WB_V,    3'd4, 1'b0);
      6'd14: u = mk(OPA_V,  OPB_M2,     WB_QADD, 3'd4, 1'b0);
      6'd15: u = mk(OPA_U,  OPB_M1,     WB_QA,   3'd5, 1'b0);
      6'd16: u = mk(OPA_QA, OPB_K15625, WB_V,    3'd5, 1'b0);
      6'd17: u = mk(OPA_V,  OPB_M2,     WB_QADD, 3'd5, 1'b0);
      // Terms built on g*x.
      6'd18: u = mk(OPA_G,  OPB_X,  WB_T1,  3'd0, 1'b0);
      6'd19: u = mk(OPA_T1, OPB_D0, WB_ADD, 3'd0, 1'b0);
      6'd20: u = mk(OPA_T1, OPB_D1, WB_ADD, 3'd1, 1'b0);
      6'd21: u = mk(OPA_T1, OPB_PZ, WB_T2,  3'd0, 1'b0);
      6'd22: u = mk(OPA_T2, OPB_D0, WB_ADD, 3'd4, 1'b0);
      6'd23: u = mk(OPA_T2, OPB_D1, WB_SUB, 3'd3, 1'b0);
      6'd24: u = mk(OPA_T1, OPB_PY, WB_T2,  3'd0, 1'b0);
      6'd25: u = mk(OPA_T2, OPB_D0, WB_SUB, 3'd5, 1'b0);
      6'd26: u = mk(OPA_T1, OPB_PX, WB_T2,  3'd0, 1'b0);
      6'd27: u = mk(OPA_T2, OPB_D1, WB_ADD, 3'd5, 1'b0);
      // Terms built on g*y.
      6'd28: u = mk(OPA_G,  OPB_Y,  WB_T1,  3'd0, 1'b0);
      6'd29: u = mk(OPA_T1, OPB_D0, WB_SUB, 3'd1, 1'b0);
      6'd30: u = mk(OPA_T1, OPB_D1, WB_ADD, 3'd0, 1'b0);
      6'd31: u = mk(OPA_T1, OPB_PZ, WB_T2,  3'd0, 1'b0);
      6'd32: u = mk(OPA_T2, OPB_D0, WB_ADD, 3'd3, 1'b0);
      6'd33: u = mk(OPA_T2, OPB_D1, WB_ADD, 3'd4, 1'b0);
      6'd34: u = mk(OPA_T1, OPB_PY, WB_T2,  3'd0, 1'b0);
      6'd35: u = mk(OPA_T2, OPB_D1, WB_SUB, 3'd5, 1'b0);
      6'd36: u = mk(OPA_T1, OPB_PX, WB_T2,  3'd0, 1'b0);
      6'd37: u = mk(OPA_T2, OPB_D0, WB_SUB, 3'd5, 1'b0);
      // Lever-arm terms on d2 and the z force.
      6'd38: u = mk(OPA_G,  OPB_PY, WB_T1,  3'd0, 1'b0);
      6'd39: u = mk(OPA_T1, OPB_D2, WB_ADD, 3'd3, 1'b0);
      6'd40: u = mk(OPA_G,  OPB_PX, WB_T1,  3'd0, 1'b0);
      6'd41: u = mk(OPA_T1, OPB_D2, WB_SUB, 3'd4, 1'b0);
      6'd42: u = mk(OPA_G,  OPB_D2, WB_ADD, 3'd2, 1'b1);
      // Gravity-direction terms in Q.30.
      6'd43: u = mk(OPA_SS, OPB_S6, WB_T1,  3'd0, 1'b0);
      6'd44: u = mk(OPA_T1, OPB_C5, WB_ADD, 3'd0, 1'b0);
      6'd45: u = mk(OPA_CS, OPB_S6, WB_ADD, 3'd0, 1'b0);
      6'd46: u = mk(OPA_SS, OPB_C5, WB_T1,  3'd0, 1'b0);
      6'd47: u = mk(OPA_T1, OPB_S6, WB_SUB, 3'd1, 1'b0);
      6'd48: u = mk(OPA_CS, OPB_C6, WB_ADD, 3'd1, 1'b0);
      6'd49: u = mk(OPA_SS, OPB_S5, WB_SUB, 3'd2, 1'b1);
      default: u = mk(OPA_G, OPB_X, WB_T1, 3'd0, 1'b1);
    endcase
    return u;
  endfunction

endpackage

// File: design/ftgc_sample_if.sv
// ----------------------------------------------------------------------------
// ftgc_sample_if: input channel of the gravity compensation block
// Carries one joint or wrench item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ftgc_sample_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] shoulder_lift;
  logic signed [15:0] elbow;
  logic signed [15:0] wrist_one;
  logic signed [15:0] wrist_two;
  logic signed [15:0] wrist_three;
  logic signed [31:0] raw_force_x;
  logic signed [31:0] raw_force_y;
  logic signed [31:0] raw_force_z;
  logic signed [31:0] raw_torque_x;
  logic signed [31:0] raw_torque_y;
  logic signed [31:0] raw_torque_z;

  modport source (
    output valid, mode, shoulder_lift, elbow, wrist_one, wrist_two, wrist_three,
           raw_force_x, raw_force_y, raw_force_z, raw_torque_x, raw_torque_y,
           raw_torque_z,
    input  ready
  );

  modport sink (
    input  valid, mode, shoulder_lift, elbow, wrist_one, wrist_two, wrist_three,
           raw_force_x, raw_force_y, raw_force_z, raw_torque_x, raw_torque_y,
           raw_torque_z,
    output ready
  );
endinterface

// File: design/ftgc_wrench_if.sv
// ----------------------------------------------------------------------------
// ftgc_wrench_if: output channel of the gravity compensation block
// Carries one compensated wrench with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ftgc_wrench_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] comp_force_x;
  logic signed [31:0] comp_force_y;
  logic signed [31:0] comp_force_z;
  logic signed [31:0] comp_torque_x;
  logic signed [31:0] comp_torque_y;
  logic signed [31:0] comp_torque_z;

  modport source (
    output valid, comp_force_x, comp_force_y, comp_force_z, comp_torque_x,
           comp_torque_y, comp_torque_z,
    input  ready
  );

  modport sink (
    input  valid, comp_force_x, comp_force_y, comp_force_z, comp_torque_x,
           comp_torque_y, comp_torque_z,
    output ready
  );
endinterface

// File: design/ft_sensor_gravity_compensation.sv
// Wrench transaction: 43 steps of the one shared 33x33 multiplier, each a
// multiply state and a writeback state, then a finish state that waits for
// the output register to be free; the next transaction is accepted in idle.
// Joint transaction: for each of three angles a reduction, then CORDIC
// rotations, then the gravity-direction multiplier steps; the shared CORDIC unit
// runs once per angle. One transaction at a time; input ready only when idle.
// Synchronous active-high reset clears configuration and stored terms to zero.
// ----------------------------------------------------------------------------
// ft_sensor_gravity_compensation: wrist force/torque gravity compensation
// A joint transaction updates three gravity-direction terms with CORDIC;
// a wrench transaction scales the raw sensor values and applies the terms.
// ----------------------------------------------------------------------------
module ft_sensor_gravity_compensation
  import ftgc_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  ftgc_sample_if.sink         sample,
  ftgc_wrench_if.source       wrench,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  localparam int IW = $clog2(CORDIC_STEPS + 1);
  localparam logic [IW-1:0] ITER_LAST = IW'(CORDIC_STEPS);

  typedef enum logic [2:0] {
    S_IDLE, S_RED, S_ROT, S_MUL, S_WB, S_JFIN, S_FIN
  } state_t;

  // Configuration.
  logic signed [31:0] g, ofx, ofy, ofz, otx, oty, otz, tx, ty, px, py, pz;

  // Sequencer and datapath registers.
  state_t             state;
  logic [5:0]         step;
  logic               mode_r;
  logic signed [15:0] a5, a6;
  logic signed [31:0] raw [6];
  logic signed [35:0] acc [6];
  logic signed [31:0] gd [3];
  logic signed [31:0] t1, t2;
  logic [17:0]        qa;
  logic [23:0]        v;
  logic signed [65:0] prod;
  logic [1:0]         ang;
  logic               flip;
  logic [IW-1:0]      iter;
  logic signed [33:0] cx, cy;
  logic signed [35:0] cz;
  logic signed [31:0] ss, cs, s5, c5, s6, c6;
  logic               out_valid;
  logic signed [31:0] out_w [6];

  // Combinational helpers.
  uop_t               uc;
  logic signed [32:0] opa_val, opb_val;
  logic signed [32:0] raw_sel, u;
  logic signed [31:0] mq16;
  logic signed [35:0] mres;
  logic signed [32:0] ra;
  logic [28:0]        q29;
  logic signed [35:0] qs;
  logic signed [17:0] jsum;
  logic signed [33:0] cordic_sn, cordic_cs;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      g <= '0; ofx <= '0; ofy <= '0; ofz <= '0; otx <= '0; oty <= '0;
      otz <= '0; tx <= '0; ty <= '0; px <= '0; py <= '0; pz <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRAVITY_WEIGHT:  g <= cfg_data[31:0];
        REG_FORCE_OFFSET_XY: begin ofx <= cfg_data[31:0]; ofy <= cfg_data[63:32]; end
        REG_OFFSET_FZ_TX:    begin ofz <= cfg_data[31:0]; otx <= cfg_data[63:32]; end
        REG_OFFSET_TY_TZ:    begin oty <= cfg_data[31:0]; otz <= cfg_data[63:32]; end
        REG_MOUNT_TILT_XY:   begin tx <= cfg_data[31:0]; ty <= cfg_data[63:32]; end
        REG_ARM_PXY:         begin px <= cfg_data[31:0]; py <= cfg_data[63:32]; end
        REG_ARM_PZ:          pz <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Current micro step and raw channel magnitude.
  assign uc      = ucode(step);
  assign raw_sel = 33'(raw[uc.dst]);
  assign u       = raw_sel[32] ? -raw_sel : raw_sel;
  assign jsum    = 18'(sample.shoulder_lift) + 18'(sample.elbow) + 18'(sample.wrist_one);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (uc.opa)
      OPA_G:   opa_val = 33'(g);
      OPA_T1:  opa_val = 33'(t1);
      OPA_T2:  opa_val = 33'(t2);
      OPA_U:   opa_val = u;
      OPA_QA:  opa_val = $signed({15'd0, qa});
      OPA_V:   opa_val = $signed({9'd0, v});
      OPA_SS:  opa_val = 33'(ss);
      OPA_CS:  opa_val = 33'(cs);
      default: opa_val = '0;
    endcase
    case (uc.opb)
      OPB_X:      opb_val = 33'(tx);
      OPB_Y:      opb_val = 33'(ty);
      OPB_PX:     opb_val = 33'(px);
      OPB_PY:     opb_val = 33'(py);
      OPB_PZ:     opb_val = 33'(pz);
      OPB_D0:     opb_val = 33'(gd[0]);
      OPB_D1:     opb_val = 33'(gd[1]);
      OPB_D2:     opb_val = 33'(gd[2]);
      OPB_M1:     opb_val = RECIP_15625_K45;
      OPB_K15625: opb_val = DIV_15625;
      OPB_M2:     opb_val = RECIP_15625_K38;
      OPB_S5:     opb_val = 33'(s5);
      OPB_C5:     opb_val = 33'(c5);
      OPB_S6:     opb_val = 33'(s6);
      OPB_C6:     opb_val = 33'(c6);
      default:    opb_val = '0;
    endcase
  end

  // Product scaling: Q16.16 saturated for wrench work, Q.30 for joint work.
  always_comb begin
    mq16 = sat32(50'(prod >>> 16));
    mres = mode_r ? 36'(mq16) : 36'(prod >>> 30);
    ra   = u - $signed(prod[32:0]);
    q29  = {1'b0, qa, 10'd0} + 29'(prod[48:38]);
    qs   = raw_sel[32] ? -$signed({7'd0, q29}) : $signed({7'd0, q29});
    cordic_sn = flip ? -cy : cy;
    cordic_cs = flip ? -cx : cx;
  end

  // Sequencer, CORDIC unit, multiplier and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      step      <= WRENCH_FIRST;
      gd[0]     <= '0;
      gd[1]     <= '0;
      gd[2]     <= '0;
    end else begin
      // The finish state decides the output register by itself.
      if (wrench.valid && wrench.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            mode_r <= sample.mode;
            a5     <= sample.wrist_two;
            a6     <= sample.wrist_three;
            raw[0] <= sample.raw_force_x;
            raw[1] <= sample.raw_force_y;
            raw[2] <= sample.raw_force_z;
            raw[3] <= sample.raw_torque_x;
            raw[4] <= sample.raw_torque_y;
            raw[5] <= sample.raw_torque_z;
            if (sample.mode) begin
              acc[0] <= -36'(ofx);
              acc[1] <= -36'(ofy);
              acc[2] <= -36'(ofz);
              acc[3] <= -36'(otx);
              acc[4] <= -36'(oty);
              acc[5] <= -36'(otz);
              step   <= WRENCH_FIRST;
              state  <= S_MUL;
            end else begin
              for (int k = 0; k < 6; k++) acc[k] <= '0;
              cz    <= {{2{jsum[17]}}, jsum, 16'd0};
              ang   <= 2'd0;
              state <= S_RED;
            end
          end
        end
        // Bring the angle into (-pi, pi], then fold into [-pi/2, pi/2].
        S_RED: begin
          if (cz > Q28_PI) begin
            cz <= cz - Q28_TWO_PI;
          end else if (cz <= -Q28_PI) begin
            cz <= cz + Q28_TWO_PI;
          end else begin
            if (cz > Q28_HALF_PI) begin
              cz   <= cz - Q28_PI;
              flip <= 1'b1;
            end else if (cz < -Q28_HALF_PI) begin
              cz   <= cz + Q28_PI;
              flip <= 1'b1;
            end else begin
              flip <= 1'b0;
            end
            cx    <= CORDIC_GAIN;
            cy    <= '0;
            iter  <= '0;
            state <= S_ROT;
          end
        end
        // One CORDIC rotation per cycle, then store sine and cosine.
        S_ROT: begin
          if (iter != ITER_LAST) begin
            if (!cz[35]) begin
              cx <= cx - (cy >>> iter);
              cy <= cy + (cx >>> iter);
              cz <= cz - $signed({8'd0, atan_q28(5'(iter))});
            end else begin
              cx <= cx + (cy >>> iter);
              cy <= cy - (cx >>> iter);
              cz <= cz + $signed({8'd0, atan_q28(5'(iter))});
            end
            iter <= iter + 1'b1;
          end else begin
            case (ang)
              2'd0: begin ss <= 32'(cordic_sn); cs <= 32'(cordic_cs); end
              2'd1: begin s5 <= 32'(cordic_sn); c5 <= 32'(cordic_cs); end
              default: begin s6 <= 32'(cordic_sn); c6 <= 32'(cordic_cs); end
            endcase
            if (ang == 2'd2) begin
              step  <= JOINT_FIRST;
              state <= S_MUL;
            end else begin
              cz    <= (ang == 2'd0) ? {{4{a5[15]}}, a5, 16'd0}
                                     : {{4{a6[15]}}, a6, 16'd0};
              ang   <= ang + 2'd1;
              state <= S_RED;
            end
          end
        end
        S_MUL: begin
          prod  <= opa_val * opb_val;
          state <= S_WB;
        end
        // Write the registered product back as the micro step says.
        S_WB: begin
          case (uc.wb)
            WB_T1:   t1 <= 32'(mres);
            WB_T2:   t2 <= 32'(mres);
            WB_ADD:  acc[uc.dst] <= acc[uc.dst] + mres;
            WB_SUB:  acc[uc.dst] <= acc[uc.dst] - mres;
            WB_QA:   qa <= prod[62:45];
            WB_V:    v  <= {ra[13:0], 10'd0} + ROUND_BIAS;
            WB_QADD: acc[uc.dst] <= acc[uc.dst] + qs;
            default: ;
          endcase
          if (uc.last) begin
            state <= mode_r ? S_FIN : S_JFIN;
          end else begin
            step  <= step + 6'd1;
            state <= S_MUL;
          end
        end
        S_JFIN: begin
          for (int k = 0; k < 3; k++) gd[k] <= 32'(acc[k] >>> 14);
          state <= S_IDLE;
        end
        // Hand the wrench to the output register once it is free.
        S_FIN: begin
          if (!out_valid || wrench.ready) begin
            for (int k = 0; k < 6; k++) out_w[k] <= sat32(50'(acc[k]));
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sample.ready         = (state == S_IDLE);
  assign wrench.valid         = out_valid;
  assign wrench.comp_force_x  = out_w[0];
  assign wrench.comp_force_y  = out_w[1];
  assign wrench.comp_force_z  = out_w[2];
  assign wrench.comp_torque_x = out_w[3];
  assign wrench.comp_torque_y = out_w[4];
  assign wrench.comp_torque_z = out_w[5];

`ifndef SYNTHESIS
  // An accepted transaction always keeps the block busy for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("input accepted while a transaction was in progress");

  // A new result appears only out of the final state of a wrench transaction.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(wrench.valid) |-> $past(state) == S_FIN)
    else $error("result raised outside the wrench finish state");

  // The multiplier never runs past the end of the step table.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> step <= STEP_LAST)
    else $error("micro step out of range");
`endif

endmodule
